// ===== design/tes_pkg.sv =====
// ----------------------------------------------------------------------------
// tes_pkg
// Types and constants shared by the track edge steering extractor.
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam int ROW_PIXELS_DEF = 128;
  localparam int FRAME_ROWS_DEF = 64;
  localparam int MAX_RUNS_DEF   = 10;

  localparam logic [1:0] CFG_GRAY_THRESHOLD  = 2'd0;
  localparam logic [1:0] CFG_MIN_RUN_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_STEER_REFERENCE = 2'd2;
  localparam logic [1:0] CFG_JUMP_LIMIT      = 2'd3;

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_TRACK  = 2'd1,
    MODE_STOP   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_PIXEL,
    ST_SCAN,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [5:0] row_number;
    logic       edge_valid;
    logic [6:0] left_edge;
    logic [6:0] right_edge;
    logic       frame_done;
    logic [7:0] steering;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [19:0] dividend;
    logic [10:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [19:0] quotient;
  } div_rsp_t;

endpackage

// ===== design/tes_divider.sv =====
// ----------------------------------------------------------------------------
// tes_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tes_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  tes_pkg::div_req_t req,
  output tes_pkg::div_rsp_t rsp
);
  import tes_pkg::*;

  logic [19:0] quo_r, quo_nxt;
  logic [10:0] den_r, den_nxt;
  logic [11:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [11:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[10:0], quo_r[19]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      den_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[18:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[18:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd19) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== design/track_edge_steering_extract.sv =====
// ----------------------------------------------------------------------------
// track_edge_steering_extract
// Run-length track follower with row-weighted centroid steering.
// ----------------------------------------------------------------------------
// Pixels enter on the in_ channel, one transaction per pixel, in scan order.
// Mid-row pixels are taken one per cycle: the run boundaries go into a small
// synchronous run memory. At the end of a row the block reads the run memory
// back, one run per cycle (none once tracking has stopped), updates the sums
// and registers one result on out_ as it leaves the output state. After the
// row-end transaction in_stall stays high through the scan and sum states,
// at a frame end the divide state, where a 20-step restoring divider produces
// the steering value, and the output state, which a new result holds while
// out_stall keeps the result register full. Reset restores the register
// defaults, search mode and a steering value of 64. The run memory is not
// cleared: only entries written in the current row are ever used.
// ----------------------------------------------------------------------------
module track_edge_steering_extract #(
  parameter int ROW_PIXELS = tes_pkg::ROW_PIXELS_DEF,
  parameter int FRAME_ROWS = tes_pkg::FRAME_ROWS_DEF,
  parameter int MAX_RUNS   = tes_pkg::MAX_RUNS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tes_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tes_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import tes_pkg::*;

  localparam int PW = $clog2(ROW_PIXELS);
  localparam int RW = $clog2(FRAME_ROWS);
  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;

  // configuration
  logic [7:0] thr_r, minw_r, sref_r, jlim_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= 8'd128;
      minw_r <= 8'd20;
      sref_r <= 8'd64;
      jlim_r <= 8'd90;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRAY_THRESHOLD:  thr_r  <= cfg_data;
        CFG_MIN_RUN_WIDTH:   minw_r <= cfg_data;
        CFG_STEER_REFERENCE: sref_r <= cfg_data;
        CFG_JUMP_LIMIT:      jlim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // run memory: {start, end}
  logic [2*PW-1:0] run_mem [MAX_RUNS];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [2*PW-1:0] mem_wdata, mem_rdata;
  always_ff @(posedge clk) begin
    if (mem_we) run_mem[mem_waddr] <= mem_wdata;
    mem_rdata <= run_mem[mem_raddr];
  end

  state_t st_r, st_nxt;
  logic          prev_white_r, prev_white_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] start_r, start_nxt;
  mode_t         mode_r, mode_nxt;
  logic [PW-1:0] ll_r, ll_nxt, lr_r, lr_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [19:0]   wsum_r, wsum_nxt;
  logic [10:0]   wtot_r, wtot_nxt;
  logic [7:0]    steer_r, steer_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic          hit_r, hit_nxt;
  logic [PW:0]   best_r, best_nxt;
  logic [PW-1:0] ps_r, ps_nxt, pe_r, pe_nxt;
  logic          last_r, last_nxt;
  logic          vld_r, vld_nxt;
  out_item_t     od_r, od_nxt;
  logic          ov_r, ov_nxt;

  div_req_t dreq;
  div_rsp_t drsp;
  tes_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic          acc, white, row_done;
  logic [PW-1:0] rs, re;
  logic [PW:0]   w, ctr, lctr, cdist;
  logic          ovl;
  logic [7:0]    sv;
  logic [8:0]    sd;

  assign acc      = in_valid && !in_stall;
  assign white    = in_data.pixel > thr_r;
  assign row_done = in_data.row_end || in_data.frame_end ||
                    (pos_r == PW'(ROW_PIXELS - 1));
  assign rs = mem_rdata[2*PW-1:PW];
  assign re = mem_rdata[PW-1:0];
  assign w  = {1'b0, re} - {1'b0, rs};
  assign ctr  = ({1'b0, rs} + {1'b0, re}) >> 1;
  assign lctr = ({1'b0, ll_r} + {1'b0, lr_r}) >> 1;
  assign cdist = (ctr > lctr) ? ctr - lctr : lctr - ctr;
  assign ovl  = ((re < lr_r) ? re : lr_r) >= ((rs > ll_r) ? rs : ll_r);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_PIXEL: if (acc && row_done) st_nxt = ST_SCAN;
      ST_SCAN:  if (scan_r == cnt_r || mode_r == MODE_STOP) st_nxt = ST_SUM;
      ST_SUM:   st_nxt = last_r ? ST_DIV : ST_OUT;
      ST_DIV:   if (drsp.done) st_nxt = ST_OUT;
      ST_OUT:   if (!ov_r || !out_stall) st_nxt = ST_PIXEL;
      default:  st_nxt = ST_PIXEL;
    endcase
  end

  always_comb begin
    prev_white_nxt = prev_white_r;
    cnt_nxt = cnt_r; pos_nxt = pos_r; start_nxt = start_r;
    mode_nxt = mode_r; ll_nxt = ll_r; lr_nxt = lr_r; row_nxt = row_r;
    wsum_nxt = wsum_r; wtot_nxt = wtot_r; steer_nxt = steer_r;
    scan_nxt = scan_r; hit_nxt = hit_r; best_nxt = best_r;
    ps_nxt = ps_r; pe_nxt = pe_r; last_nxt = last_r; vld_nxt = vld_r;
    od_nxt = od_r; ov_nxt = ov_r;
    mem_we = 1'b0; mem_waddr = cnt_r[AW-1:0];
    mem_wdata = {start_r, pos_r}; mem_raddr = scan_r[AW-1:0];
    dreq = '{start: 1'b0, dividend: wsum_r, divisor: wtot_r};
    sv = steer_r; sd = '0;
    in_stall = (st_r != ST_PIXEL);
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (st_r)
      ST_PIXEL: if (acc) begin
        if (white && !prev_white_r) start_nxt = pos_r;
        if (cnt_r < CW'(MAX_RUNS) && ((!white && prev_white_r) || (white && row_done))) begin
          mem_we = 1'b1;
          mem_wdata = {(white && !prev_white_r) ? pos_r : start_r, pos_r};
          cnt_nxt = cnt_r + 1'b1;
        end
        prev_white_nxt = white;
        pos_nxt = pos_r + 1'b1;
        if (row_done) begin
          last_nxt = in_data.frame_end || (row_r == RW'(FRAME_ROWS - 1));
          scan_nxt = '0; hit_nxt = 1'b0; best_nxt = '0;
        end
      end
      ST_SCAN: begin
        // data read last cycle belongs to run scan_r-1
        if (scan_r != '0) begin
          if (mode_r == MODE_SEARCH) begin
            if (!hit_r || w >= best_r) begin
              best_nxt = w; ps_nxt = rs; pe_nxt = re; hit_nxt = 1'b1;
            end
          end else if (ovl && (!hit_r || cdist < best_r)) begin
            best_nxt = cdist; ps_nxt = rs; pe_nxt = re; hit_nxt = 1'b1;
          end
        end
        if (scan_r != cnt_r && mode_r != MODE_STOP) scan_nxt = scan_r + 1'b1;
      end
      ST_SUM: begin
        vld_nxt = 1'b0;
        if (mode_r == MODE_SEARCH) begin
          if (hit_r && best_r > {1'b0, minw_r[PW-1:0]} && (minw_r >> PW) == 8'd0) begin
            vld_nxt = 1'b1; mode_nxt = MODE_TRACK;
          end
        end else if (mode_r == MODE_TRACK) begin
          if (hit_r) vld_nxt = 1'b1;
          else mode_nxt = MODE_STOP;
        end
        if (vld_nxt) begin
          ll_nxt = ps_r; lr_nxt = pe_r;
          wtot_nxt = wtot_r + 11'(row_r);
          wsum_nxt = wsum_r + 20'(row_r) *
                     20'(({1'b0, ps_r} + {1'b0, pe_r}) >> 1);
        end
        dreq.start = last_r;
        dreq.dividend = wsum_nxt;
        dreq.divisor = wtot_nxt;
      end
      ST_DIV: if (drsp.done) begin
        if (wtot_r != '0)
          sv = (drsp.quotient > 20'(ROW_PIXELS)) ? 8'(ROW_PIXELS) : drsp.quotient[7:0];
        sd = (sv > sref_r) ? 9'(sv) - 9'(sref_r) : 9'(sref_r) - 9'(sv);
        if (sd > 9'(jlim_r)) sv = sref_r;
        steer_nxt = sv;
      end
      ST_OUT: if (!ov_r || !out_stall) begin
        od_nxt.row_number = 6'(row_r);
        od_nxt.edge_valid = vld_r;
        od_nxt.left_edge  = vld_r ? 7'(ll_r) : 7'd0;
        od_nxt.right_edge = vld_r ? 7'(lr_r) : 7'd0;
        od_nxt.frame_done = last_r;
        od_nxt.steering   = steer_r;
        ov_nxt = 1'b1;
        if (last_r) begin
          row_nxt = '0; mode_nxt = MODE_SEARCH; wsum_nxt = '0; wtot_nxt = '0;
        end else row_nxt = row_r + 1'b1;
        cnt_nxt = '0; pos_nxt = '0; prev_white_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_PIXEL; prev_white_r <= 1'b0; cnt_r <= '0; pos_r <= '0;
      mode_r <= MODE_SEARCH; ll_r <= '0; lr_r <= '0; row_r <= '0;
      wsum_r <= '0; wtot_r <= '0; steer_r <= 8'd64; ov_r <= 1'b0;
      scan_r <= '0; hit_r <= 1'b0; last_r <= 1'b0; vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt; prev_white_r <= prev_white_nxt; cnt_r <= cnt_nxt;
      pos_r <= pos_nxt; mode_r <= mode_nxt; ll_r <= ll_nxt; lr_r <= lr_nxt;
      row_r <= row_nxt; wsum_r <= wsum_nxt; wtot_r <= wtot_nxt;
      steer_r <= steer_nxt; ov_r <= ov_nxt; scan_r <= scan_nxt;
      hit_r <= hit_nxt; last_r <= last_nxt; vld_r <= vld_nxt;
    end
    start_r <= start_nxt; best_r <= best_nxt;
    ps_r <= ps_nxt; pe_r <= pe_nxt; od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule
